### hdl/shg_pkg.sv
// ----------------------------------------------------------------------------
// shg_pkg
// Shared widths, register indexes and fixed-point constants for the stereo
// high-pass / low-pass / gain chain.
// ----------------------------------------------------------------------------
package shg_pkg;

    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int COEFF_W  = 17;
    localparam int GAIN_W   = 19;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [SAMPLE_W-1:0] UNITY = SAMPLE_W'(1) << FRAC_W;
    localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(1) << FRAC_W;

    localparam logic [REG_IDX_W-1:0] REG_HPF_EN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HPF_COEFF = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LPF_EN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LPF_COEFF = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MUTE      = 3'd5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

### hdl/stereo_hpf_lpf_gain_chain_unit.sv
// ----------------------------------------------------------------------------
// stereo_hpf_lpf_gain_chain_unit
// Per-side one-pole high-pass, one-pole low-pass and gain on Q16.16 stereo
// pairs, built around one shared 32x32 signed multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one stereo pair with its active
//   and block-end flags per beat. Output channel (o_valid / i_ready) returns
//   one processed pair per input beat, in order.
//   o_ready is high only while the sequencer is idle; one pair is worked on
//   at a time. Each side runs high-pass (S_HP, plus S_HP_WB when enabled),
//   low-pass (S_LP, plus S_LP2 and S_LP_WB when enabled) and gain (S_GAIN,
//   S_G_WB) on the shared multiplier, then the pair moves to S_DONE.
//   A muted or inactive pair goes from S_IDLE straight to S_DONE. From S_DONE
//   the result enters the output register once it is free, and the sequencer
//   returns to S_IDLE, where the next pair is accepted.
//   Adders aside, the multiplier is the single arithmetic unit; its product is registered.
//   The output register holds a finished beat while the receiver stalls;
//   the next pair is accepted and processed meanwhile and waits in the
//   result stage until the output register frees up.
//   APB registers: 0 hpf_enable, 1 hpf_coeff, 2 lpf_enable, 3 lpf_coeff,
//   4 gain, 5 mute at byte addresses 4*i. Writing a filter register clears
//   that filter's history. Write only while idle.
//   Reset (synchronous, active low) clears the sequencer, the output valid,
//   all filter histories and the registers (gain to unity).
// ----------------------------------------------------------------------------
module stereo_hpf_lpf_gain_chain_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [shg_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [shg_pkg::SAMPLE_W-1:0] i_right_in,
    input  logic                         i_instrument_active,
    input  logic                         i_block_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [shg_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [shg_pkg::SAMPLE_W-1:0] o_right_out,
    output logic                         o_audible,
    output logic                         o_block_end_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shg_pkg::ADDR_W-1:0]   paddr,
    input  logic [shg_pkg::DATA_W-1:0]   pwdata,
    output logic [shg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HP    = 4'd1;
    localparam logic [3:0] S_HP_WB = 4'd2;
    localparam logic [3:0] S_LP    = 4'd3;
    localparam logic [3:0] S_LP2   = 4'd4;
    localparam logic [3:0] S_LP_WB = 4'd5;
    localparam logic [3:0] S_GAIN  = 4'd6;
    localparam logic [3:0] S_G_WB  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int SW = shg_pkg::SAMPLE_W;
    localparam int FW = shg_pkg::FRAC_W;
    localparam int PW = shg_pkg::PROD_W;

    logic [3:0]                   r_state, n_state;
    logic                         r_side;
    shg_pkg::t_sample             r_x, r_right, r_acc, r_resl, r_resr;
    logic                         r_aud, r_blk;
    logic signed [shg_pkg::PROD_W-1:0] r_prod;

    shg_pkg::t_sample             r_hp_pin [2];
    shg_pkg::t_sample             r_hp_pout[2];
    shg_pkg::t_sample             r_lp_pout[2];

    logic                         r_hpf_en, r_lpf_en, r_mute;
    logic [shg_pkg::COEFF_W-1:0]  r_hpf_coeff, r_lpf_coeff;
    logic [shg_pkg::GAIN_W-1:0]   r_gain;

    logic                         r_ovalid;
    shg_pkg::t_sample             r_oleft, r_oright;
    logic                         r_oaud, r_oblk;

    logic                         w_in_acc, w_cfg_wr, w_out_free;
    logic [shg_pkg::REG_IDX_W-1:0] w_idx;
    shg_pkg::t_sample             w_ma, w_mb, w_pslice, w_hp_sum, w_oma;
    logic signed [shg_pkg::PROD_W-1:0] w_prod;
    logic                         w_mul_en;
    logic                         w_clr_hp, w_clr_lp;

    assign w_in_acc   = i_valid && o_ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_idx      = paddr[shg_pkg::ADDR_W-1:2];
    assign w_out_free = !r_ovalid || i_ready;
    assign w_clr_hp   = w_cfg_wr && (w_idx == shg_pkg::REG_HPF_EN ||
                                     w_idx == shg_pkg::REG_HPF_COEFF);
    assign w_clr_lp   = w_cfg_wr && (w_idx == shg_pkg::REG_LPF_EN ||
                                     w_idx == shg_pkg::REG_LPF_COEFF);

    assign w_pslice = r_prod[SW+FW-1:FW];
    assign w_hp_sum = r_hp_pout[r_side] + r_x - r_hp_pin[r_side];
    assign w_oma    = shg_pkg::UNITY - {{(SW-shg_pkg::COEFF_W){1'b0}}, r_lpf_coeff};

    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b0;
        unique case (r_state)
            S_HP: begin
                w_ma     = {{(SW-shg_pkg::COEFF_W){1'b0}}, r_hpf_coeff};
                w_mb     = w_hp_sum;
                w_mul_en = r_hpf_en;
            end
            S_LP: begin
                w_ma     = {{(SW-shg_pkg::COEFF_W){1'b0}}, r_lpf_coeff};
                w_mb     = r_x;
                w_mul_en = r_lpf_en;
            end
            S_LP2: begin
                w_ma     = w_oma;
                w_mb     = r_lp_pout[r_side];
                w_mul_en = 1'b1;
            end
            S_GAIN: begin
                w_ma     = {{(SW-shg_pkg::GAIN_W){1'b0}}, r_gain};
                w_mb     = r_x;
                w_mul_en = 1'b1;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_prod = PW'(w_ma) * PW'(w_mb);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_instrument_active && !r_mute) ? S_HP : S_DONE;
                end
            end
            S_HP:    n_state = r_hpf_en ? S_HP_WB : S_LP;
            S_HP_WB: n_state = S_LP;
            S_LP:    n_state = r_lpf_en ? S_LP2 : S_GAIN;
            S_LP2:   n_state = S_LP_WB;
            S_LP_WB: n_state = S_GAIN;
            S_GAIN:  n_state = S_G_WB;
            S_G_WB:  n_state = r_side ? S_DONE : S_HP;
            S_DONE:  n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_side <= 1'b0;
            end else if (r_state == S_G_WB) begin
                r_side <= 1'b1;
            end
        end

        if (w_mul_en) begin
            r_prod <= w_prod;
        end

        if (w_in_acc) begin
            r_x     <= i_left_in;
            r_right <= i_right_in;
            r_resl  <= i_left_in;
            r_resr  <= i_right_in;
            r_aud   <= i_instrument_active && !r_mute;
            r_blk   <= i_block_end;
        end

        unique case (r_state)
            S_HP_WB: r_x <= w_pslice;
            S_LP2:   r_acc <= w_pslice;
            S_LP_WB: r_x <= r_acc + w_pslice;
            S_G_WB: begin
                if (r_side) begin
                    r_resr <= w_pslice;
                end else begin
                    r_resl <= w_pslice;
                    r_x    <= r_right;
                end
            end
            default: begin
            end
        endcase
    end

    // filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr_hp) begin
            r_hp_pin[0]  <= '0;
            r_hp_pin[1]  <= '0;
            r_hp_pout[0] <= '0;
            r_hp_pout[1] <= '0;
        end else begin
            if (r_state == S_HP && r_hpf_en) begin
                r_hp_pin[r_side] <= r_x;
            end
            if (r_state == S_HP_WB) begin
                r_hp_pout[r_side] <= w_pslice;
            end
        end
        if (!i_rst_n || w_clr_lp) begin
            r_lp_pout[0] <= '0;
            r_lp_pout[1] <= '0;
        end else if (r_state == S_LP_WB) begin
            r_lp_pout[r_side] <= r_acc + w_pslice;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_oleft  <= r_resl;
            r_oright <= r_resr;
            r_oaud   <= r_aud;
            r_oblk   <= r_blk;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_left_out      = r_oleft;
    assign o_right_out     = r_oright;
    assign o_audible       = r_oaud;
    assign o_block_end_out = r_oblk;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpf_en    <= 1'b0;
            r_hpf_coeff <= '0;
            r_lpf_en    <= 1'b0;
            r_lpf_coeff <= '0;
            r_gain      <= shg_pkg::GAIN_RESET;
            r_mute      <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                shg_pkg::REG_HPF_EN:    r_hpf_en    <= pwdata[0];
                shg_pkg::REG_HPF_COEFF: r_hpf_coeff <= pwdata[shg_pkg::COEFF_W-1:0];
                shg_pkg::REG_LPF_EN:    r_lpf_en    <= pwdata[0];
                shg_pkg::REG_LPF_COEFF: r_lpf_coeff <= pwdata[shg_pkg::COEFF_W-1:0];
                shg_pkg::REG_GAIN:      r_gain      <= pwdata[shg_pkg::GAIN_W-1:0];
                shg_pkg::REG_MUTE:      r_mute      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            shg_pkg::REG_HPF_EN:    prdata[0] = r_hpf_en;
            shg_pkg::REG_HPF_COEFF: prdata[shg_pkg::COEFF_W-1:0] = r_hpf_coeff;
            shg_pkg::REG_LPF_EN:    prdata[0] = r_lpf_en;
            shg_pkg::REG_LPF_COEFF: prdata[shg_pkg::COEFF_W-1:0] = r_lpf_coeff;
            shg_pkg::REG_GAIN:      prdata[shg_pkg::GAIN_W-1:0] = r_gain;
            shg_pkg::REG_MUTE:      prdata[0] = r_mute;
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    a_hp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_hp |=> (r_hp_pin[0] == '0 && r_hp_pin[1] == '0 &&
                      r_hp_pout[0] == '0 && r_hp_pout[1] == '0))
        else $error("high-pass history not cleared after register write");

    a_lp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_lp |=> (r_lp_pout[0] == '0 && r_lp_pout[1] == '0))
        else $error("low-pass history not cleared after register write");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !(i_instrument_active && !r_mute)) |=>
            (r_state == S_DONE && !r_aud))
        else $error("silent pair did not take the bypass path");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("output valid raised outside the result stage");

    a_side_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_aud || r_side))
        else $error("audible pair finished before the right side");

endmodule

### tb/shg_chain_checker.sv
// ----------------------------------------------------------------------------
// shg_chain_checker
// Watches the sample, result and register channels of the stereo filter/gain
// chain, predicts each result pair from its own copy of the registers and
// filter histories, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module shg_chain_checker
    import shg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  t_sample             in_left,
    input  t_sample             in_right,
    input  logic                in_active,
    input  logic                in_block_end,
    input  logic                out_valid,
    input  logic                out_ready,
    input  t_sample             out_left,
    input  t_sample             out_right,
    input  logic                out_audible,
    input  logic                out_block_end,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output int                  mismatch_count,
    output int                  pairs_pending,
    output int                  pairs_checked,
    output int                  audible_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_sample left;
        t_sample right;
        logic    audible;
        logic    block_end;
    } t_pair_out;

    logic                hpf_on;
    logic                lpf_on;
    logic                muted;
    logic [COEFF_W-1:0]  hpf_alpha;
    logic [COEFF_W-1:0]  lpf_alpha;
    logic [GAIN_W-1:0]   gain_q;
    logic [SAMPLE_W-1:0] hp_x_hist [2];
    logic [SAMPLE_W-1:0] hp_y_hist [2];
    logic [SAMPLE_W-1:0] lp_y_hist [2];
    t_pair_out           expected_pairs [$];
    t_pair_out           want;

    function automatic logic signed [PROD_W-1:0] widen(input logic [SAMPLE_W-1:0] v);
        return {{SAMPLE_W{v[SAMPLE_W-1]}}, v};
    endfunction

    // floor shift, then wrap to sample width
    function automatic logic [SAMPLE_W-1:0] qmul(input logic signed [PROD_W-1:0] a,
                                                 input logic signed [PROD_W-1:0] b);
        logic signed [PROD_W-1:0] p;
        p = a * b;
        return p[FRAC_W+SAMPLE_W-1:FRAC_W];
    endfunction

    function automatic void clear_highpass();
        hp_x_hist[0] = '0;
        hp_x_hist[1] = '0;
        hp_y_hist[0] = '0;
        hp_y_hist[1] = '0;
    endfunction

    function automatic void clear_lowpass();
        lp_y_hist[0] = '0;
        lp_y_hist[1] = '0;
    endfunction

    function automatic void apply_write(input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] data);
        case (addr[REG_IDX_W+1:2])
            REG_HPF_EN: begin
                hpf_on = data[0];
                clear_highpass();
            end
            REG_HPF_COEFF: begin
                hpf_alpha = data[COEFF_W-1:0];
                clear_highpass();
            end
            REG_LPF_EN: begin
                lpf_on = data[0];
                clear_lowpass();
            end
            REG_LPF_COEFF: begin
                lpf_alpha = data[COEFF_W-1:0];
                clear_lowpass();
            end
            REG_GAIN: gain_q = data[GAIN_W-1:0];
            REG_MUTE: muted = data[0];
            default: ;
        endcase
    endfunction

    function automatic t_pair_out chain_step(input t_sample l, input t_sample r,
                                             input logic act, input logic be);
        t_pair_out           res;
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] one_minus;
        res.left      = l;
        res.right     = r;
        res.audible   = act && !muted;
        res.block_end = be;
        if (res.audible) begin
            for (int k = 0; k < 2; k++) begin
                x = (k == 0) ? l : r;
                if (hpf_on) begin
                    y = qmul(PROD_W'(hpf_alpha), widen(hp_y_hist[k] + x - hp_x_hist[k]));
                    hp_x_hist[k] = x;
                    hp_y_hist[k] = y;
                    x = y;
                end
                if (lpf_on) begin
                    one_minus = UNITY - SAMPLE_W'(lpf_alpha);
                    y = qmul(PROD_W'(lpf_alpha), widen(x))
                        + qmul(widen(one_minus), widen(lp_y_hist[k]));
                    lp_y_hist[k] = y;
                    x = y;
                end
                x = qmul(widen(x), PROD_W'(gain_q));
                if (k == 0) begin
                    res.left = x;
                end else begin
                    res.right = x;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hpf_on    = 1'b0;
            lpf_on    = 1'b0;
            muted     = 1'b0;
            hpf_alpha = '0;
            lpf_alpha = '0;
            gain_q    = GAIN_RESET;
            clear_highpass();
            clear_lowpass();
            expected_pairs.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (expected_pairs.size() == 0) begin
                    mismatch_count++;
                    $error("result beat with no pair outstanding");
                end else begin
                    want = expected_pairs.pop_front();
                    pairs_checked++;
                    if (out_audible === 1'b1) audible_seen++;
                    if (want.left !== out_left) begin
                        mismatch_count++;
                        $error("left_out: expected %0d, got %0d", want.left, out_left);
                    end
                    if (want.right !== out_right) begin
                        mismatch_count++;
                        $error("right_out: expected %0d, got %0d", want.right, out_right);
                    end
                    if (want.audible !== out_audible) begin
                        mismatch_count++;
                        $error("audible: expected %0d, got %0d", want.audible, out_audible);
                    end
                    if (want.block_end !== out_block_end) begin
                        mismatch_count++;
                        $error("block_end_out: expected %0d, got %0d",
                               want.block_end, out_block_end);
                    end
                end
            end
            if (in_valid && in_ready) begin
                expected_pairs.push_back(chain_step(in_left, in_right, in_active,
                                                    in_block_end));
            end
            if (psel && penable && pwrite && pready) begin
                apply_write(paddr, pwdata);
            end
        end
        pairs_pending = expected_pairs.size();
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives stereo sample pairs and register settings into the filter/gain
// chain with random idle gaps on both channels, and reports the verdict
// from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW    = shg_pkg::ADDR_W;
    localparam int DW    = shg_pkg::DATA_W;
    localparam int IDX_W = shg_pkg::REG_IDX_W;

    localparam int RESET_CYCLES  = 9;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RAND_PHASES   = 16;
    localparam int PHASE_PAIRS   = 52;
    localparam int SETTLE_CYCLES = 32;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd6;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    shg_pkg::t_sample    i_left_in;
    shg_pkg::t_sample    i_right_in;
    logic                i_instrument_active;
    logic                i_block_end;
    logic                o_valid;
    logic                i_ready;
    shg_pkg::t_sample    o_left_out;
    shg_pkg::t_sample    o_right_out;
    logic                o_audible;
    logic                o_block_end_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AW-1:0]       paddr;
    logic [DW-1:0]       pwdata;
    logic [DW-1:0]       prdata;
    logic                pready;

    int mismatch_count;
    int pairs_pending;
    int pairs_checked;
    int audible_seen;
    int pairs_sent;
    int reg_writes;
    int quiet_cycles;
    bit no_idle;
    bit hold_req;

    stereo_hpf_lpf_gain_chain_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_left_in           (i_left_in),
        .i_right_in          (i_right_in),
        .i_instrument_active (i_instrument_active),
        .i_block_end         (i_block_end),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_left_out          (o_left_out),
        .o_right_out         (o_right_out),
        .o_audible           (o_audible),
        .o_block_end_out     (o_block_end_out),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    shg_chain_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .in_valid       (i_valid),
        .in_ready       (o_ready),
        .in_left        (i_left_in),
        .in_right       (i_right_in),
        .in_active      (i_instrument_active),
        .in_block_end   (i_block_end),
        .out_valid      (o_valid),
        .out_ready      (i_ready),
        .out_left       (o_left_out),
        .out_right      (o_right_out),
        .out_audible    (o_audible),
        .out_block_end  (o_block_end_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pairs_pending  (pairs_pending),
        .pairs_checked  (pairs_checked),
        .audible_seen   (audible_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic shg_pkg::t_sample rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return shg_pkg::t_sample'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            default: return shg_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_reg_value(input logic [IDX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 9);
        case (idx)
            shg_pkg::REG_HPF_COEFF, shg_pkg::REG_LPF_COEFF: begin
                if (r == 0) return '0;
                if (r == 1) return 32'h1_0000;
                if (r < 7) return $urandom_range(0, 32'h1_0000);
                if (r < 9) return $urandom_range(0, 32'h1_FFFF);
                return $urandom;
            end
            shg_pkg::REG_GAIN: begin
                if (r == 0) return '0;
                if (r == 1) return 32'h4_0000;
                if (r == 2) return 32'h1_0000;
                if (r < 9) return $urandom_range(0, 32'h4_0000);
                return $urandom;
            end
            shg_pkg::REG_MUTE: begin
                if (r == 0) return 32'd1;
                return {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, 1'b0};
            end
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge with the bus idle
    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DW-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= AW'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        reg_writes++;
    endtask

    task automatic write_setting(input logic hen, input logic [DW-1:0] hco,
                                 input logic len, input logic [DW-1:0] lco,
                                 input logic [DW-1:0] g, input logic m);
        apb_write(shg_pkg::REG_HPF_EN, DW'(hen));
        apb_write(shg_pkg::REG_HPF_COEFF, hco);
        apb_write(shg_pkg::REG_LPF_EN, DW'(len));
        apb_write(shg_pkg::REG_LPF_COEFF, lco);
        apb_write(shg_pkg::REG_GAIN, g);
        apb_write(shg_pkg::REG_MUTE, DW'(m));
    endtask

    task automatic send_pair(input shg_pkg::t_sample l, input shg_pkg::t_sample r,
                             input logic act, input logic be);
        int gap;
        i_valid             <= 1'b1;
        i_left_in           <= l;
        i_right_in          <= r;
        i_instrument_active <= act;
        i_block_end         <= be;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        pairs_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_pair();
        send_pair(rand_sample(), rand_sample(), $urandom_range(0, 7) != 0,
                  $urandom_range(0, 15) == 0);
    endtask

    task automatic wait_all_results();
        if (i_valid) i_valid <= 1'b0;
        wait (pairs_pending == 0);
        @(negedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        i_ready = 1'b0;
        repeat (RESET_CYCLES + 1) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_left_in           = '0;
        i_right_in          = '0;
        i_instrument_active = 1'b0;
        i_block_end         = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        no_idle             = 1'b0;
        hold_req            = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: bypass, unity gain
        send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0);
        send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_pair(32'sh0, 32'sh0, 1'b1, 1'b0);
        send_pair(-32'sh1, 32'sh1, 1'b1, 1'b1);
        send_pair(32'sh1234_5678, -32'sh10000, 1'b0, 1'b0);
        send_pair(32'sh0001_0000, 32'shFFFF_0000, 1'b1, 1'b1);
        wait_all_results();

        // unity alphas, gain of 4.0
        write_setting(1'b1, 32'h1_0000, 1'b1, 32'h1_0000, 32'h4_0000, 1'b0);
        send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0);
        send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_pair(32'sh0, -32'sh1, 1'b1, 1'b0);
        send_pair(32'sh0003_8000, -32'sh0002_4000, 1'b0, 1'b1);
        send_pair(-32'sh1, 32'sh0, 1'b1, 1'b1);
        send_pair(32'sh0001_0000, 32'sh0001_0000, 1'b1, 1'b0);
        wait_all_results();

        // high-pass bypassed, low-pass alpha above unity
        write_setting(1'b0, 32'h0, 1'b1, 32'h1_FFFF, 32'h4_0000, 1'b0);
        send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0);
        send_pair(32'sh0002_0000, -32'sh0002_0000, 1'b1, 1'b0);
        send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1);
        send_pair(-32'sh1, 32'sh1, 1'b1, 1'b0);
        wait_all_results();

        // half alpha high-pass, zero gain
        write_setting(1'b1, 32'h8000, 1'b0, 32'h0, 32'h0, 1'b0);
        send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0);
        send_pair(32'sh0005_0000, -32'sh0005_0000, 1'b1, 1'b1);
        wait_all_results();

        // muted, plus a write to an unmapped register
        apb_write(shg_pkg::REG_MUTE, 32'hFFFF_FFFF);
        apb_write(REG_UNMAPPED, $urandom);
        send_pair(32'sh1357_9BDF, 32'sh8000_0000, 1'b1, 1'b0);
        send_pair(32'sh7FFF_FFFF, -32'sh1, 1'b0, 1'b1);
        send_pair(32'sh0, 32'sh0, 1'b1, 1'b1);
        wait_all_results();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            no_idle = (ph % 5 == 4);
            for (int idx = shg_pkg::REG_HPF_EN; idx <= shg_pkg::REG_MUTE; idx++) begin
                if (ph == 0 || $urandom_range(0, 2) != 0) begin
                    apb_write(IDX_W'(idx), rand_reg_value(IDX_W'(idx)));
                end
            end
            if ($urandom_range(0, 3) == 0) apb_write(REG_UNMAPPED, $urandom);
            if (ph == 3) hold_req = 1'b1;
            for (int n = 0; n < PHASE_PAIRS; n++) begin
                if (ph == 7 && n == PHASE_PAIRS / 2) wait_all_results();
                send_random_pair();
            end
            wait_all_results();
        end

        no_idle = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("covered %0d stereo pairs, %0d of them audible, across %0d register writes",
                 pairs_sent, audible_seen, reg_writes);
        $display("checked %0d result beats, %0d field mismatches",
                 pairs_checked, mismatch_count);
        if (mismatch_count == 0 && pairs_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/shg_pkg.sv
hdl/stereo_hpf_lpf_gain_chain_unit.sv
tb/shg_chain_checker.sv
tb/tb_top.sv
